// File: design/eec_pkg.sv
`timescale 1ns / 1ps
// eec_pkg: field widths and counter sizing for the extended euclid block
// no dependencies; imported by extended_euclid_coefficients

package eec_pkg;

   // operand and gcd width
   localparam int OPND_W = 31;
   // width of the coefficient result fields
   localparam int OUT_W  = 32;
   // bit counter of the shared divider
   localparam int CNT_W  = $clog2(OPND_W);

endpackage : eec_pkg

// File: design/extended_euclid_coefficients.sv
`timescale 1ns / 1ps
// extended_euclid_coefficients: bezout coefficients and gcd of two operands
// depends on eec_pkg
//
// usage
//   req channel (req_valid / req_ready) carries operand_a and operand_b, one beat
//   per item. rsp channel (rsp_valid / rsp_ready) returns one beat per item with
//   coef_b, coef_a, gcd_value and divide_by_zero, where
//   coef_a * operand_a + coef_b * operand_b = gcd_value (modulo 2^WIDTH).
//   a zero operand_b returns divide_by_zero with all other fields zero.
//   each euclid step runs a restoring divider one quotient bit per cycle,
//   with the quotient-times-coefficient products built alongside from the
//   same quotient bits, then an update state moves the coefficient rows.
//   an item runs one step per division (at most about 46 for 31-bit operands).
//   req_ready is high only while the sequencer is idle; a finished result sits
//   in the output register, so the next item can be taken while rsp is stalled.
//   a stalled rsp holds the next result in the sequencer until the beat leaves.
//   reset empties the output register and returns the sequencer to idle.

module extended_euclid_coefficients
   import eec_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OPND_W-1:0]       req_operand_a,
   input  logic [OPND_W-1:0]       req_operand_b,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_coef_b,
   output logic signed [OUT_W-1:0] rsp_coef_a,
   output logic [OPND_W-1:0]       rsp_gcd_value,
   output logic                    rsp_divide_by_zero
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [OPND_W-1:0]    num_ff, num_in;
   logic [OPND_W-1:0]    den_ff, den_in;
   logic [OPND_W-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]     a_prev_ff, a_prev_in;
   logic [WIDTH-1:0]     b_prev_ff, b_prev_in;
   logic [WIDTH-1:0]     a_cur_ff, a_cur_in;
   logic [WIDTH-1:0]     b_cur_ff, b_cur_in;
   logic [WIDTH-1:0]     pa_ff, pa_in;
   logic [WIDTH-1:0]     pb_ff, pb_in;
   logic                 dz_ff, dz_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_coef_b_ff, rsp_coef_b_in;
   logic [OUT_W-1:0]     rsp_coef_a_ff, rsp_coef_a_in;
   logic [OPND_W-1:0]    rsp_gcd_ff, rsp_gcd_in;
   logic                 rsp_dz_ff, rsp_dz_in;

   // restoring divider step
   logic [OPND_W:0]      rem_shift;
   logic [OPND_W:0]      den_ext;
   logic [OPND_W:0]      rem_diff;
   logic                 q_bit;

   assign rem_shift = {rem_ff, num_ff[OPND_W-1]};
   assign den_ext   = {1'b0, den_ff};
   assign rem_diff  = rem_shift - den_ext;
   assign q_bit     = (rem_shift >= den_ext);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      a_prev_in     = a_prev_ff;
      b_prev_in     = b_prev_ff;
      a_cur_in      = a_cur_ff;
      b_cur_in      = b_cur_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      dz_in         = dz_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_coef_b_in = rsp_coef_b_ff;
      rsp_coef_a_in = rsp_coef_a_ff;
      rsp_gcd_in    = rsp_gcd_ff;
      rsp_dz_in     = rsp_dz_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in    = req_operand_a;
               den_in    = req_operand_b;
               rem_in    = '0;
               cnt_in    = '0;
               pa_in     = '0;
               pb_in     = '0;
               a_prev_in = WIDTH'(1);
               b_prev_in = '0;
               a_cur_in  = '0;
               b_cur_in  = WIDTH'(1);
               dz_in     = (req_operand_b == '0);
               state_in  = (req_operand_b == '0) ? ST_FINISH : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = q_bit ? rem_diff[OPND_W-1:0] : rem_shift[OPND_W-1:0];
            num_in = {num_ff[OPND_W-2:0], 1'b0};
            // products q * a_cur and q * b_cur, msb-first from the quotient bits
            pa_in  = {pa_ff[WIDTH-2:0], 1'b0} + (q_bit ? a_cur_ff : '0);
            pb_in  = {pb_ff[WIDTH-2:0], 1'b0} + (q_bit ? b_cur_ff : '0);
            if (cnt_ff == CNT_W'(OPND_W - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_UPDATE: begin
            if (rem_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               a_prev_in = a_cur_ff;
               b_prev_in = b_cur_ff;
               a_cur_in  = a_prev_ff - pa_ff;
               b_cur_in  = b_prev_ff - pb_ff;
               num_in    = den_ff;
               den_in    = rem_ff;
               rem_in    = '0;
               pa_in     = '0;
               pb_in     = '0;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_dz_in     = dz_ff;
               rsp_coef_b_in = dz_ff ? '0 : OUT_W'(b_cur_ff);
               rsp_coef_a_in = dz_ff ? '0 : OUT_W'(a_cur_ff);
               rsp_gcd_in    = dz_ff ? '0 : den_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      a_prev_ff     <= a_prev_in;
      b_prev_ff     <= b_prev_in;
      a_cur_ff      <= a_cur_in;
      b_cur_ff      <= b_cur_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      dz_ff         <= dz_in;
      rsp_coef_b_ff <= rsp_coef_b_in;
      rsp_coef_a_ff <= rsp_coef_a_in;
      rsp_gcd_ff    <= rsp_gcd_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coef_b         = rsp_coef_b_ff;
   assign rsp_coef_a         = rsp_coef_a_ff;
   assign rsp_gcd_value      = rsp_gcd_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   // partial remainder never reaches the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (den_ff != '0) && (rem_ff < den_ff))
      else $error("divider remainder out of range");

   // coefficient update only after a full set of quotient bits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(state_ff) == ST_DIV) &&
                                  ($past(cnt_ff) == CNT_W'(OPND_W - 1)))
      else $error("update entered before division finished");

   // a zero divisor beat carries only the flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dz_ff) |->
         (rsp_coef_b_ff == '0) && (rsp_coef_a_ff == '0) && (rsp_gcd_ff == '0))
      else $error("divide by zero beat with nonzero fields");

   // a normal result always has a nonzero gcd
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_dz_ff) |-> (rsp_gcd_ff != '0))
      else $error("zero gcd without divide by zero");

   // a new result is loaded only into a free or draining output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("result dropped while output stalled");

endmodule : extended_euclid_coefficients
